// ----- design/ccfb_pkg.sv -----
`default_nettype none

package ccfb_pkg;

    localparam int unsigned VOLT_IN_W  = 16;
    localparam int unsigned POWER_W    = 18;
    localparam int unsigned VOLT_W     = 13;
    localparam int unsigned CURR_W     = 13;
    localparam int unsigned DIVIDEND_W = 24;
    localparam int unsigned DIV_CNT_W  = 5;
    localparam int unsigned FRAME_DATA = 7;

    localparam logic [7:0]            CRC_POLY     = 8'h1D;
    localparam logic [7:0]            CRC_INIT     = 8'hFF;
    localparam logic [VOLT_W-1:0]     VOLT_MAX     = 13'h1FFF;
    localparam logic [VOLT_IN_W-1:0]  VOLT_MIN_DIV = 16'd10;
    localparam logic [CURR_W-1:0]     CURR_MAX     = 13'd7000;
    localparam logic [DIVIDEND_W-1:0] POWER_SCALE  = 24'd100;
    localparam logic [DIV_CNT_W-1:0]  DIV_LAST     = 5'(DIVIDEND_W - 1);

    // One byte through the CRC8 register, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/ccfb_if.sv -----
`default_nettype none

interface ccfb_in_if import ccfb_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic                        charge_mode;
    logic                        charge_enable;
    logic        [VOLT_IN_W-1:0] volt_setpoint_dv;
    logic signed [POWER_W-1:0]   power_setpoint_w;

    modport source (
        output valid, charge_mode, charge_enable, volt_setpoint_dv, power_setpoint_w,
        input  ready
    );
    modport sink (
        input  valid, charge_mode, charge_enable, volt_setpoint_dv, power_setpoint_w,
        output ready
    );
endinterface

interface ccfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [7:0] byte_6;
    logic [7:0] byte_7;

    modport source (
        output valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        input  ready
    );
    modport sink (
        input  valid, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/ccfb_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ccfb_div import ccfb_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [DIVIDEND_W-1:0] i_dividend,
    input  wire logic [VOLT_IN_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic      [DIVIDEND_W-1:0] o_quotient
);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt,  n_cnt;
    logic [VOLT_IN_W-1:0]  r_rem,  n_rem;
    logic [DIVIDEND_W-1:0] r_quo,  n_quo;
    logic [VOLT_IN_W-1:0]  r_dvs,  n_dvs;
    logic [VOLT_IN_W:0]    trial;
    logic [VOLT_IN_W:0]    diff;

    always_comb begin
        trial  = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // keep the difference when the trial value covers the divisor
            if (!diff[VOLT_IN_W]) begin
                n_rem = diff[VOLT_IN_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = trial[VOLT_IN_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- design/ccfb_crc.sv -----
`default_nettype none

// CRC8 register, one byte folded in per step.
module ccfb_crc import ccfb_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_clear,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_crc
);

    logic [7:0] r_crc, n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_clear) begin
            n_crc = CRC_INIT;
        end else if (i_step) begin
            n_crc = crc8_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_crc = ~r_crc;

endmodule

`default_nettype wire

// ----- design/charge_command_frame_builder.sv -----
// From an input transfer with charge mode set, the frame passes the divider steps, the done
//   flag, the pack state, the CRC steps over bytes 0 to 6 and the output load before output valid.
// No new item is taken until the frame is loaded into the output register, as the bit-serial
//   divider and byte-serial CRC hold the sequencer; a stalled output holds it longer.
// An item with charge mode clear is taken, gives no frame and leaves the sequencer idle.
// Reset (synchronous, active low) clears the rolling counter, the sequencer and output valid.
`default_nettype none

module charge_command_frame_builder import ccfb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ccfb_in_if.sink   i_cmd,
    ccfb_out_if.source o_frame
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PACK,
        S_CRC,
        S_LOAD
    } t_state;

    t_state                r_state, n_state;
    logic                  r_en;
    logic [VOLT_W-1:0]     r_volt;
    logic                  r_neg;
    logic [3:0]            r_roll, n_roll;
    logic [2:0]            r_idx,  n_idx;
    logic [7:0]            r_frm [FRAME_DATA];
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out [8];

    logic                  in_xfer;
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quo;
    logic [DIVIDEND_W-1:0] dividend;
    logic [VOLT_IN_W-1:0]  divisor;
    logic [CURR_W-1:0]     curr;
    logic [CURR_W-1:0]     code;
    logic                  crc_clear;
    logic                  crc_step;
    logic [7:0]            crc_byte;
    logic [7:0]            crc_val;
    logic                  out_free;

    // Accept only when the sequencer is free and out of reset.
    assign i_cmd.ready = (r_state == S_IDLE) && i_rst_n;
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign div_start   = in_xfer && i_cmd.charge_mode;

    // Scale the non-negative power by 100; a negative power is cut off at pack time.
    assign dividend = DIVIDEND_W'({1'b0, i_cmd.power_setpoint_w[POWER_W-2:0]}) * POWER_SCALE;
    assign divisor  = (i_cmd.volt_setpoint_dv < VOLT_MIN_DIV) ? VOLT_MIN_DIV
                                                              : i_cmd.volt_setpoint_dv;

    ccfb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Clamp the current request to its range, then code it as 7000 minus the request.
    always_comb begin
        if (r_neg) begin
            curr = '0;
        end else if (div_quo > DIVIDEND_W'(CURR_MAX)) begin
            curr = CURR_MAX;
        end else begin
            curr = div_quo[CURR_W-1:0];
        end
        code = CURR_MAX - curr;
    end

    // Feed bytes 0 through 6 into the CRC, one per cycle.
    assign crc_clear = (r_state == S_PACK);
    assign crc_step  = (r_state == S_CRC);
    assign crc_byte  = r_frm[r_idx];

    ccfb_crc u_crc (
        .i_clk   (i_clk),
        .i_clear (crc_clear),
        .i_step  (crc_step),
        .i_byte  (crc_byte),
        .o_crc   (crc_val)
    );

    // The output register frees up when empty or when its frame transfers this cycle.
    assign out_free = !r_out_valid || o_frame.ready;

    always_comb begin
        n_state     = r_state;
        n_roll      = r_roll;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_frame.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                // drop the item when charge mode is clear
                if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                n_roll  = r_roll + 1'b1;
                n_idx   = '0;
                n_state = S_CRC;
            end
            S_CRC: begin
                n_idx = r_idx + 1'b1;
                if (r_idx == 3'(FRAME_DATA - 1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                // hold until the output register can take the frame
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_roll      <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_roll      <= n_roll;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end

        if (div_start) begin
            r_en   <= i_cmd.charge_enable;
            r_neg  <= i_cmd.power_setpoint_w[POWER_W-1];
            r_volt <= (i_cmd.volt_setpoint_dv > VOLT_IN_W'(VOLT_MAX))
                      ? VOLT_MAX : i_cmd.volt_setpoint_dv[VOLT_W-1:0];
        end

        // Pack the first seven bytes; the rolling count goes in before it advances.
        if (r_state == S_PACK) begin
            r_frm[0] <= {r_en, 7'd0};
            r_frm[1] <= {3'd0, r_volt[12:8]};
            r_frm[2] <= r_volt[7:0];
            r_frm[3] <= r_volt[12:5];
            r_frm[4] <= {r_volt[4:0], code[12:10]};
            r_frm[5] <= code[9:2];
            r_frm[6] <= {code[1:0], r_en, 1'b0, r_roll};
        end

        if (r_state == S_LOAD && out_free) begin
            for (int j = 0; j < FRAME_DATA; j++) begin
                r_out[j] <= r_frm[j];
            end
            r_out[7] <= crc_val;
        end
    end

    assign o_frame.valid  = r_out_valid;
    assign o_frame.byte_0 = r_out[0];
    assign o_frame.byte_1 = r_out[1];
    assign o_frame.byte_2 = r_out[2];
    assign o_frame.byte_3 = r_out[3];
    assign o_frame.byte_4 = r_out[4];
    assign o_frame.byte_5 = r_out[5];
    assign o_frame.byte_6 = r_out[6];
    assign o_frame.byte_7 = r_out[7];

endmodule

`default_nettype wire

// ----- design/ccfb_chk.sv -----
`default_nettype none

module ccfb_chk import ccfb_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       i_in_ready,
    input wire logic       i_in_mode,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_byte_0,
    input wire logic [7:0] i_byte_1,
    input wire logic [7:0] i_byte_6,
    input wire logic [7:0] i_byte_7
);

    // A charging command occupies the sequencer.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_mode |=> !i_in_ready)
        else $error("ready stayed high after a charging command");

    // A non-charging command is dropped and leaves the block free.
    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_mode |=> i_in_ready)
        else $error("ready fell after a dropped command");

    // Fixed-zero fields of the frame.
    a_zero_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_byte_0[6:0] == 7'd0) && (i_byte_1[7:5] == 3'd0) && !i_byte_6[4])
        else $error("reserved frame bits set");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_byte_6) && $stable(i_byte_7))
        else $error("stalled frame changed");

endmodule

bind charge_command_frame_builder ccfb_chk u_ccfb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_mode   (i_cmd.charge_mode),
    .i_out_valid (o_frame.valid),
    .i_out_ready (o_frame.ready),
    .i_byte_0    (o_frame.byte_0),
    .i_byte_1    (o_frame.byte_1),
    .i_byte_6    (o_frame.byte_6),
    .i_byte_7    (o_frame.byte_7)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
`default_nettype none

module tb_top;
    import ccfb_pkg::*;

    // One 100 ms tick as presented on the command channel
    typedef struct packed {
        logic                      charge_mode;
        logic                      charge_enable;
        logic [VOLT_IN_W-1:0]      volt_setpoint_dv;
        logic signed [POWER_W-1:0] power_setpoint_w;
    } charge_tick_t;

    // Eight frame bytes, index 0 is byte 0
    typedef logic [7:0][7:0] cmd_frame_t;

    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned TICK_TARGET  = 1150;

    logic i_clk;
    logic i_rst_n;

    ccfb_in_if  cmd_if ();
    ccfb_out_if frame_if ();

    charge_command_frame_builder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_frame (frame_if.source)
    );

    charge_tick_t queued_ticks [$];
    cmd_frame_t   frames_due [$];
    logic [3:0]   frame_seq;
    int unsigned  error_count;
    int unsigned  idle_cycles;

    // Inverted CRC8, poly 0x1D, init 0xFF, MSB first over bytes 0..6
    function automatic logic [7:0] frame_check_byte(input cmd_frame_t f);
        logic [7:0] c;
        c = 8'hFF;
        for (int i = 0; i < 7; i++) begin
            c = c ^ f[i];
            for (int k = 0; k < 8; k++) begin
                c = c[7] ? ({c[6:0], 1'b0} ^ 8'h1D) : {c[6:0], 1'b0};
            end
        end
        return ~c;
    endfunction

    function automatic cmd_frame_t build_command_frame(input charge_tick_t t,
                                                       input logic [3:0] seq);
        cmd_frame_t   f;
        logic [12:0]  volt;
        int unsigned  divisor;
        int unsigned  amps;
        logic [12:0]  code;
        volt    = (t.volt_setpoint_dv > 16'h1FFF) ? 13'h1FFF : t.volt_setpoint_dv[12:0];
        divisor = (t.volt_setpoint_dv < 16'd10) ? 10 : int'(t.volt_setpoint_dv);
        if (t.power_setpoint_w[POWER_W-1]) begin
            amps = 0;
        end else begin
            amps = (int'(t.power_setpoint_w[POWER_W-2:0]) * 100) / divisor;
            if (amps > 7000) amps = 7000;
        end
        code = 13'(7000 - amps);
        f[0] = {t.charge_enable, 7'b0};
        f[1] = {3'b0, volt[12:8]};
        f[2] = volt[7:0];
        f[3] = volt[12:5];
        f[4] = {volt[4:0], code[12:10]};
        f[5] = code[9:2];
        f[6] = {code[1:0], t.charge_enable, 1'b0, seq};
        f[7] = 8'h00;
        f[7] = frame_check_byte(f);
        return f;
    endfunction

    function automatic charge_tick_t make_tick(input logic mode, input logic en,
                                               input int unsigned volt, input int power);
        charge_tick_t t;
        t.charge_mode      = mode;
        t.charge_enable    = en;
        t.volt_setpoint_dv = VOLT_IN_W'(volt);
        t.power_setpoint_w = POWER_W'(power);
        return t;
    endfunction

    // Random tick: voltages near the edges of the divisor and the packing range,
    // power often aimed at the current range so the clamp is hit both ways
    function automatic charge_tick_t random_tick();
        int unsigned volt;
        int unsigned divisor;
        int          power;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)      volt = $urandom_range(0, 12);
        else if (pick < 60) volt = $urandom_range(0, 8191);
        else if (pick < 80) volt = $urandom_range(8180, 8200);
        else                volt = $urandom_range(0, 65535);
        divisor = (volt < 10) ? 10 : volt;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            power = -int'($urandom_range(1, 131072));
        end else if (pick < 55) begin
            power = int'(($urandom_range(0, 7600) * divisor) / 100);
            if (power > 131071) power = 131071;
        end else if (pick < 62) begin
            power = int'($urandom_range(0, 200));
        end else begin
            power = int'($urandom_range(0, 262143)) - 131072;
        end
        return make_tick($urandom_range(0, 99) < 85, 1'($urandom_range(0, 1)), volt, power);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)      return 0;
        else if (pick < 85) return $urandom_range(1, 3);
        else if (pick < 96) return $urandom_range(4, 12);
        else                return $urandom_range(20, 80);
    endfunction

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("mismatch: %s", what);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Known values on every block input from time zero
    initial begin
        cmd_if.valid            = 1'b0;
        cmd_if.charge_mode      = 1'b0;
        cmd_if.charge_enable    = 1'b0;
        cmd_if.volt_setpoint_dv = '0;
        cmd_if.power_setpoint_w = '0;
        frame_if.ready          = 1'b0;
    end

    // Stimulus, reset and end of run
    initial begin
        charge_tick_t t;
        i_rst_n     = 1'b0;
        error_count = 0;

        // Directed: not charging, enable both ways, divisor floor,
        // packing saturation, negative and extreme power, clamp edges
        queued_ticks.push_back(make_tick(1'b0, 1'b1, 1000, 50000));
        queued_ticks.push_back(make_tick(1'b1, 1'b0, 0, 0));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 0, 131071));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 9, 500));
        queued_ticks.push_back(make_tick(1'b1, 1'b0, 10, 500));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 11, 700));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 8191, 131071));
        queued_ticks.push_back(make_tick(1'b1, 1'b0, 8192, 131071));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 65535, 131071));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 65535, -131072));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 4000, -1));
        queued_ticks.push_back(make_tick(1'b1, 1'b0, 1000, 70000));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 1000, 70009));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 1000, 69999));
        queued_ticks.push_back(make_tick(1'b0, 1'b0, 65535, -131072));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 3000, 1));
        queued_ticks.push_back(make_tick(1'b1, 1'b0, 5461, 87381));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 2730, 43690));
        queued_ticks.push_back(make_tick(1'b0, 1'b1, 0, 0));
        queued_ticks.push_back(make_tick(1'b1, 1'b1, 100, 0));

        // Random: fill up to the tick target, ignored ticks included
        while (queued_ticks.size() < TICK_TARGET) begin
            t = random_tick();
            queued_ticks.push_back(t);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: wait until all ticks are transferred and every frame is back
        while (queued_ticks.size() != 0 || cmd_if.valid) @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Command driver: predict on each transfer, then offer the next tick after a random gap or back to back
    int unsigned send_gap;
    int unsigned send_calm;
    always @(posedge i_clk) begin
        charge_tick_t t;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
            frame_seq    = 4'd0;
            send_gap     = 0;
            send_calm    = 0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                t = {cmd_if.charge_mode, cmd_if.charge_enable,
                     cmd_if.volt_setpoint_dv, cmd_if.power_setpoint_w};
                if (t.charge_mode) begin
                    frames_due.push_back(build_command_frame(t, frame_seq));
                    frame_seq = frame_seq + 4'd1;
                end
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    cmd_if.valid <= 1'b0;
                end else if (queued_ticks.size() != 0) begin
                    t = queued_ticks.pop_front();
                    cmd_if.valid            <= 1'b1;
                    cmd_if.charge_mode      <= t.charge_mode;
                    cmd_if.charge_enable    <= t.charge_enable;
                    cmd_if.volt_setpoint_dv <= t.volt_setpoint_dv;
                    cmd_if.power_setpoint_w <= t.power_setpoint_w;
                    // hold off between ticks unless inside a back-to-back stretch
                    if (send_calm > 0) begin
                        send_calm--;
                    end else if ($urandom_range(0, 99) < 4) begin
                        send_calm = $urandom_range(20, 60);
                    end else begin
                        send_gap = draw_gap();
                    end
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Frame monitor: random backpressure, compare each transfer with the oldest frame due
    int unsigned stall_left;
    int unsigned recv_calm;
    always @(posedge i_clk) begin
        cmd_frame_t got;
        cmd_frame_t want;
        logic [7:0] bad_bytes;
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
            stall_left     = 0;
            recv_calm      = 0;
        end else begin
            if (frame_if.valid && frame_if.ready) begin
                got = {frame_if.byte_7, frame_if.byte_6, frame_if.byte_5, frame_if.byte_4,
                       frame_if.byte_3, frame_if.byte_2, frame_if.byte_1, frame_if.byte_0};
                if (frames_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected frame %h", got));
                end else begin
                    want = frames_due.pop_front();
                    for (int i = 0; i < 8; i++) begin
                        bad_bytes[i] = (got[i] !== want[i]);
                    end
                    if (bad_bytes != 8'h00) begin
                        flag_mismatch($sformatf("bytes %b (7..0) got %h want %h",
                                                bad_bytes, got, want));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= 1'b1;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 199) == 0) begin
                    recv_calm = $urandom_range(100, 400);
                end else if ($urandom_range(0, 9) == 0) begin
                    stall_left = draw_gap();
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) ||
            (frame_if.valid && frame_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
design/ccfb_pkg.sv
design/ccfb_if.sv
design/ccfb_div.sv
design/ccfb_crc.sv
design/charge_command_frame_builder.sv
design/ccfb_chk.sv
bench/tb_top.sv
